@@ rtl/core/brf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO with tap
// Command codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Default number of storage slots
  localparam int unsigned DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int unsigned CAP_W   = 11;  // capacity register
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 10;  // reported fill counts
  localparam int unsigned OUT_W   = 32;  // packed result word

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,  // push one byte
    CMD_READ  = 2'd1,  // pop one byte
    CMD_TAP   = 2'd2,  // read at tap, no space freed
    CMD_CLEAR = 2'd3   // zero all pointers
  } cmd_e;

endpackage

@@ rtl/core/byte_ring_fifo_with_tap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_tap: byte ring buffer with a consuming and a tap reader
// One command per request; one status result per request.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one command: write a byte, read
// and remove a byte, read a byte at the tap pointer without freeing space,
// or clear all three pointers. Every request returns exactly one result on
// the master stream with a success flag, the byte read (zero if none), the
// read and tap fill counts and the full / empty / tap-empty flags, all taken
// after the command. A request is accepted in every cycle the result
// register is empty or being drained, so a steady stream runs at one
// request per clock, results registered; the only thing that throttles
// the input is backpressure on the result register. Of the configured
// capacity one slot is always kept free; fullness looks at the read pointer
// only, so writes may overtake the tap. Writing the capacity register clamps
// it to [2, DEPTH] and clears all pointers; write it only while no request
// is in flight. Storage is a single-port-write, single-port-read RAM with
// registered read data and no reset; reading a slot never written returns
// whatever the RAM holds.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_tap #(
  parameter int unsigned DEPTH = brf_pkg::DEPTH_DEF  // storage slots, 2..65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // Capacity register
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata_i,

  // Request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [brf_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] write_byte
  input  logic [brf_pkg::CMD_W-1:0]   s_axis_tuser,   // [1:0] cmd

  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] ok, [8:1] read_byte, [18:9] readable_count, [28:19] tap_count,
  // [29] is_full, [30] is_empty, [31] tap_empty
  output logic [brf_pkg::OUT_W-1:0]   m_axis_tdata
);

  import brf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // pointer
  localparam int unsigned CW = $clog2(DEPTH + 1);                 // capacity
  localparam int unsigned MW = (CAP_W > CW) ? CAP_W : CW;         // compare
  localparam int unsigned XW = CW + COUNT_W;                      // distance

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [CW-1:0] cap_clamp(input logic [CAP_W-1:0] v);
    logic [MW-1:0] w;
    w = MW'(v);
    if (w < MW'(2)) begin
      return CW'(2);
    end else if (w > MW'(DEPTH)) begin
      return CW'(DEPTH);
    end
    return CW'(w);
  endfunction

  // Next slot, wrapping at the capacity in effect
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(p) + CW'(1);
    return (inc >= cap) ? '0 : PW'(inc);
  endfunction

  // Bytes from one pointer up to another, modulo capacity, cut to count width
  function automatic logic [COUNT_W-1:0] distance(input logic [PW-1:0] from,
                                                  input logic [PW-1:0] to,
                                                  input logic [CW-1:0] cap);
    logic [XW-1:0] d;
    if (to >= from) begin
      d = XW'(to) - XW'(from);
    end else begin
      d = XW'(cap) - XW'(from) + XW'(to);
    end
    return d[COUNT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [CW-1:0]      cap_q;
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q, tap_ptr_q;
  logic [PW-1:0]      wr_ptr_d, rd_ptr_d, tap_ptr_d;

  logic [BYTE_W-1:0]  mem [DEPTH];
  logic [BYTE_W-1:0]  rdata_q;

  // Result register
  logic               out_vld_q;
  logic               ok_q, ok_d;
  logic               rsel_q, rsel_d;      // read_byte comes from the RAM
  logic [COUNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [COUNT_W-1:0] tap_cnt_q, tap_cnt_d;
  logic               full_q, full_d;
  logic               empty_q, empty_d;
  logic               tap_empty_q, tap_empty_d;

  // --------------------------------------------------------------------------
  // Command decode and pointer update
  // --------------------------------------------------------------------------
  cmd_e               cmd;
  logic               accept;
  logic               mem_we;
  logic [PW-1:0]      rd_addr;
  logic [PW-1:0]      wr_nxt, rd_nxt, tap_nxt;
  logic               full_now;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);

  assign wr_nxt   = advance(wr_ptr_q, cap_q);
  assign rd_nxt   = advance(rd_ptr_q, cap_q);
  assign tap_nxt  = advance(tap_ptr_q, cap_q);
  assign full_now = (wr_nxt == rd_ptr_q);

  always_comb begin
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    tap_ptr_d = tap_ptr_q;
    ok_d      = 1'b0;
    rsel_d    = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = rd_ptr_q;
    case (cmd)
      CMD_WRITE: begin
        if (!full_now) begin
          wr_ptr_d = wr_nxt;
          mem_we   = accept;
          ok_d     = 1'b1;
        end
      end
      CMD_READ: begin
        if (wr_ptr_q != rd_ptr_q) begin
          rd_ptr_d = rd_nxt;
          ok_d     = 1'b1;
          rsel_d   = 1'b1;
        end
      end
      CMD_TAP: begin
        rd_addr = tap_ptr_q;
        if (wr_ptr_q != tap_ptr_q) begin
          tap_ptr_d = tap_nxt;
          ok_d      = 1'b1;
          rsel_d    = 1'b1;
        end
      end
      CMD_CLEAR: begin
        wr_ptr_d  = '0;
        rd_ptr_d  = '0;
        tap_ptr_d = '0;
        ok_d      = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Status seen after the command
  always_comb begin
    rd_cnt_d    = distance(rd_ptr_d, wr_ptr_d, cap_q);
    tap_cnt_d   = distance(tap_ptr_d, wr_ptr_d, cap_q);
    full_d      = (advance(wr_ptr_d, cap_q) == rd_ptr_d);
    empty_d     = (wr_ptr_d == rd_ptr_d);
    tap_empty_d = (wr_ptr_d == tap_ptr_d);
  end

  // --------------------------------------------------------------------------
  // Pointers and capacity
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= cap_clamp(CAP_RESET);
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      tap_ptr_q <= '0;
    end else if (cfg_we_i) begin
      cap_q     <= cap_clamp(cfg_wdata_i);
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      tap_ptr_q <= '0;
    end else if (accept) begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      tap_ptr_q <= tap_ptr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Byte RAM: read data only moves on accept, so it holds under a stall
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= s_axis_tdata;
    end
    if (accept && rsel_d) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= ok_d;
      rsel_q      <= rsel_d;
      rd_cnt_q    <= rd_cnt_d;
      tap_cnt_q   <= tap_cnt_d;
      full_q      <= full_d;
      empty_q     <= empty_d;
      tap_empty_q <= tap_empty_d;
    end
  end

  logic [BYTE_W-1:0] rbyte;
  assign rbyte = rsel_q ? rdata_q : '0;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {tap_empty_q, empty_q, full_q, tap_cnt_q, rd_cnt_q,
                          rbyte, ok_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q < PW'(cap_q - CW'(1)) || wr_ptr_q == PW'(cap_q - CW'(1))) &&
    CW'(rd_ptr_q) < cap_q && CW'(tap_ptr_q) < cap_q)
    else $error("pointer at or beyond capacity");

  a_full_write_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && cmd == CMD_WRITE && full_now |=> $stable(wr_ptr_q))
    else $error("write pointer moved on a refused write");

  a_refused_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ok_q |-> rbyte == '0)
    else $error("refused command returned data");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(full_q && empty_q))
    else $error("full and empty at once");

endmodule
